// ----- hdl/dual_timer_counter_block_assert.svh -----
// assertion macros used by the checker file
`ifndef DUAL_TIMER_COUNTER_BLOCK_ASSERT_SVH
`define DUAL_TIMER_COUNTER_BLOCK_ASSERT_SVH

// clocked check, quiet while reset is applied
`define DTC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define DTC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/dtc_pkg.sv -----
package dtc_pkg;

	// request opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// register selects
	localparam logic [2:0] REG_CTRL = 3'd0;
	localparam logic [2:0] REG_TL0  = 3'd1;
	localparam logic [2:0] REG_TH0  = 3'd2;
	localparam logic [2:0] REG_TL1  = 3'd3;
	localparam logic [2:0] REG_TH1  = 3'd4;

	// timer modes
	localparam logic [1:0] MODE_13BIT  = 2'd0;
	localparam logic [1:0] MODE_16BIT  = 2'd1;
	localparam logic [1:0] MODE_RELOAD = 2'd2;
	localparam logic [1:0] MODE_SPLIT  = 2'd3;

	// control byte bit positions
	localparam int TF1_POS = 7;
	localparam int TR1_POS = 6;
	localparam int TF0_POS = 5;
	localparam int TR0_POS = 4;

	// mode byte bit positions
	localparam int GATE1_POS = 7;
	localparam int CT1_POS   = 6;
	localparam int M1_LSB    = 4;
	localparam int GATE0_POS = 3;
	localparam int CT0_POS   = 2;
	localparam int M0_LSB    = 0;

	localparam int         PRESCALE_W = 5;
	localparam logic [7:0] BYTE_MAX   = 8'hff;

	// config port
	localparam int   CFG_ADDR_W     = 3;
	localparam int   CFG_DATA_W     = 32;
	localparam int   CFG_IDX_BIT    = 2;
	localparam logic CFG_IDX_MODE   = 1'b0;
	localparam logic CFG_IDX_SERIAL = 1'b1;

	typedef struct packed {
		logic [1:0] opcode;
		logic [2:0] register_select;
		logic [7:0] write_data;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer0_flag;
		logic       timer1_flag;
		logic       baud_pulse;
	} res_t;

	typedef struct packed {
		logic [7:0] timer_mode;
		logic       serial_mode_one;
	} cfg_t;

	typedef struct packed {
		logic [7:0] t0_low;
		logic [7:0] t0_high;
		logic [7:0] t1_low;
		logic [7:0] t1_high;
		logic [7:0] control_flags;
	} timer_state_t;

endpackage

// ----- hdl/dtc_stream_if.sv -----
interface dtc_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/dtc_cfg_regs.sv -----
module dtc_cfg_regs import dtc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);
	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			if (paddr[CFG_IDX_BIT] == CFG_IDX_SERIAL) begin
				cfg_q.serial_mode_one <= pwdata[0];
			end else begin
				cfg_q.timer_mode <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[CFG_IDX_BIT] == CFG_IDX_MODE) begin
			prdata[7:0] = cfg_q.timer_mode;
		end else begin
			prdata[0] = cfg_q.serial_mode_one;
		end
	end

	assign cfg = cfg_q;
endmodule

// ----- hdl/dtc_step_logic.sv -----
module dtc_step_logic import dtc_pkg::*; (
	input  cmd_t         cmd,
	input  cfg_t         cfg,
	input  timer_state_t cur,
	output timer_state_t nxt,
	output res_t         res
);
	typedef struct packed {
		logic [7:0] lo;
		logic [7:0] hi;
		logic       ovf;
	} cnt_t;

	// one count step in 13-bit, 16-bit or auto-reload mode
	function automatic cnt_t advance(input logic [1:0] mode, input logic [7:0] lo,
			input logic [7:0] hi);
		cnt_t                r;
		logic [PRESCALE_W:0] pre;
		logic [8:0]          lo_inc;
		logic [8:0]          hi_inc;
		pre    = {1'b0, lo[PRESCALE_W-1:0]} + {{PRESCALE_W{1'b0}}, 1'b1};
		lo_inc = {1'b0, lo} + 9'd1;
		hi_inc = {1'b0, hi} + 9'd1;
		r.lo   = lo;
		r.hi   = hi;
		r.ovf  = 1'b0;
		case (mode)
			MODE_13BIT: begin
				r.lo = {lo[7:PRESCALE_W], pre[PRESCALE_W-1:0]};
				if (pre[PRESCALE_W]) begin
					r.hi  = hi_inc[7:0];
					r.ovf = hi_inc[8];
				end
			end
			MODE_16BIT: begin
				r.lo = lo_inc[7:0];
				if (lo_inc[8]) begin
					r.hi  = hi_inc[7:0];
					r.ovf = hi_inc[8];
				end
			end
			MODE_RELOAD: begin
				if (lo_inc[8]) begin
					r.lo  = hi;
					r.ovf = 1'b1;
				end else begin
					r.lo = lo_inc[7:0];
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	logic [1:0] m0;
	logic [1:0] m1;
	logic       run0;
	logic       run1;
	logic       split;
	cnt_t       adv0;
	cnt_t       adv1;
	logic       pulse;
	logic [7:0] rd;

	assign m0    = cfg.timer_mode[M0_LSB +: 2];
	assign m1    = cfg.timer_mode[M1_LSB +: 2];
	assign run0  = !cfg.timer_mode[GATE0_POS] && cur.control_flags[TR0_POS]
		&& !cfg.timer_mode[CT0_POS];
	assign run1  = !cfg.timer_mode[GATE1_POS] && cur.control_flags[TR1_POS]
		&& !cfg.timer_mode[CT1_POS];
	assign split = (m0 == MODE_SPLIT);
	assign adv0  = advance(m0, cur.t0_low, cur.t0_high);
	assign adv1  = advance(m1, cur.t1_low, cur.t1_high);

	always_comb begin
		nxt   = cur;
		pulse = 1'b0;
		rd    = '0;
		case (cmd.opcode)
			OP_TICK: begin
				if (split) begin
					// TL0 and TH0 run as two 8-bit timers
					if (run0) begin
						if (cur.t0_low == BYTE_MAX) nxt.control_flags[TF0_POS] = 1'b1;
						nxt.t0_low = cur.t0_low + 8'd1;
					end
					if (run1) begin
						if (cur.t0_high == BYTE_MAX) nxt.control_flags[TF1_POS] = 1'b1;
						nxt.t0_high = cur.t0_high + 8'd1;
					end
				end else if (run0) begin
					nxt.t0_low  = adv0.lo;
					nxt.t0_high = adv0.hi;
					if (adv0.ovf) nxt.control_flags[TF0_POS] = 1'b1;
				end
				if (run1) begin
					nxt.t1_low  = adv1.lo;
					nxt.t1_high = adv1.hi;
					if (adv1.ovf && !split) nxt.control_flags[TF1_POS] = 1'b1;
					// serial bit clock consumes the flag
					if (nxt.control_flags[TF1_POS] && cfg.serial_mode_one) begin
						pulse = 1'b1;
						nxt.control_flags[TF1_POS] = 1'b0;
					end
				end
			end
			OP_WRITE: begin
				case (cmd.register_select)
					REG_CTRL: nxt.control_flags = cmd.write_data;
					REG_TL0:  nxt.t0_low        = cmd.write_data;
					REG_TH0:  nxt.t0_high       = cmd.write_data;
					REG_TL1:  nxt.t1_low        = cmd.write_data;
					REG_TH1:  nxt.t1_high       = cmd.write_data;
					default: begin
					end
				endcase
			end
			OP_READ: begin
				case (cmd.register_select)
					REG_CTRL: rd = cur.control_flags;
					REG_TL0:  rd = cur.t0_low;
					REG_TH0:  rd = cur.t0_high;
					REG_TL1:  rd = cur.t1_low;
					REG_TH1:  rd = cur.t1_high;
					default:  rd = '0;
				endcase
			end
			default: begin
			end
		endcase
	end

	assign res.read_data   = rd;
	assign res.timer0_flag = nxt.control_flags[TF0_POS];
	assign res.timer1_flag = nxt.control_flags[TF1_POS];
	assign res.baud_pulse  = pulse;
endmodule

// ----- hdl/dual_timer_counter_block.sv -----
// dual timer/counter block: timer 0 and timer 1 of a classic 8-bit controller
// cmd channel: one request per machine-cycle tick, register write or register read
//   (opcode, register_select, write_data); valid/ready, taken when both are high
// rsp channel: exactly one result per request, in request order
//   (read_data, timer0_flag, timer1_flag, baud_pulse)
// apb port: mode byte at byte address 0, serial mode one select at address 4;
//   pready is tied high, write only while no request is in flight
// a request taken on cmd goes to the input register, then its result to the result register, which drives rsp
// throughput: one request per clock while rsp does not stall; the input register feeds a single pass of
//   increment/compare logic that updates the timer registers and the result register
// the timer registers only change when a request leaves the input register, so
//   each request sees exactly the state left by the one before it
// rsp stall: the result register holds; the input register can still take one
//   more request, then cmd.ready drops until rsp drains
// reset (arst_n low): timers, control byte, mode byte and valids clear at once;
//   no clearing pass, the block takes requests as soon as reset is released
module dual_timer_counter_block import dtc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	dtc_stream_if.sink            cmd,
	dtc_stream_if.source          rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);
	cfg_t         cfg;
	cmd_t         cmd_s1;
	logic         cmd_vld_s1;
	timer_state_t state_q;
	timer_state_t state_nxt;
	res_t         res_nxt;
	res_t         res_q;
	logic         res_vld_q;
	logic         out_free;
	logic         s1_adv;

	// configuration registers and apb decode
	dtc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// result register is free when empty or being drained this cycle
	assign out_free  = !res_vld_q || rsp.ready;
	assign s1_adv    = cmd_vld_s1 && out_free;
	assign cmd.ready = !cmd_vld_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			cmd_vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cmd.data;
		end
	end

	// single pass: tick, write or read against the current timer state
	dtc_step_logic u_step_logic (
		.cmd (cmd_s1),
		.cfg (cfg),
		.cur (state_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// architectural timer state, committed as the request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_adv) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (out_free) begin
			res_vld_q <= cmd_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res_nxt;
		end
	end

	assign rsp.valid = res_vld_q;
	assign rsp.data  = res_q;
endmodule

// ----- hdl/dtc_checker.sv -----
`include "dual_timer_counter_block_assert.svh"

module dtc_checker import dtc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input res_t rsp_data,
	input logic pready
);
	logic rsp_stall;
	logic rsp_pulse;

	assign rsp_stall = rsp_valid && !rsp_ready;
	assign rsp_pulse = rsp_valid && rsp_data.baud_pulse;

	`DTC_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid, "rsp dropped while stalled")
	`DTC_ASSERT(a_rsp_stable, rsp_stall |=> $stable(rsp_data), "rsp changed while stalled")
	`DTC_ASSERT(a_pulse_clears_tf1, rsp_pulse |-> !rsp_data.timer1_flag, "baud pulse left tf1 set")
	`DTC_ASSERT(a_cmd_ready_free, !rsp_valid |-> cmd_ready, "cmd stalled with empty result register")
	`DTC_ASSERT_ALWAYS(a_pready_high, pready, "pready low")
endmodule

bind dual_timer_counter_block dtc_checker u_dtc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_ready (cmd.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data),
	.pready    (pready)
);
